// ----- rtl/core/grid_local_peak_counter_assert.svh -----
// Assertion macros shared by the grid peak counter modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef GRID_LOCAL_PEAK_COUNTER_ASSERT_SVH
`define GRID_LOCAL_PEAK_COUNTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/glpc_pkg.sv -----
// Shared types and constants for the grid local peak counter.
// No dependencies; used by every module of the block except glpc_ram.
package glpc_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int VALUE_WIDTH = 32;

    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int ROW_W      = 16;
    localparam int CFG_COLS_W = 11;
    localparam int PEAK_W     = 26;
    localparam int CELL_W     = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int RAM_W      = 2 * VALUE_WIDTH;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

    typedef logic signed [VALUE_WIDTH-1:0] glpc_value_t;

    // Position of one cell in the grid, as seen by the compare stage.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             c_ge1;
        logic             c_ge2;
        logic             r_ge1;
        logic             r_ge2;
        logic             last_row;
        logic             last_col;
    } glpc_pos_t;

endpackage

// ----- rtl/core/grid_local_peak_counter.sv -----
// Top level of the grid local peak counter.
// Depends on glpc_pkg, glpc_scan, glpc_ram and glpc_peak.
//
// The grid size is written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data): index 0 sets the row count, index 1 the column count. A write to
// either register restarts the current grid. The user must make writes only while
// no transaction is in flight; the block does not enforce this. cfg_ready is always high.
// Grid values arrive on the s_ channel in raster order, one per transaction.
// After the last cell of a grid a single m_ transaction carries the number of
// strict four-neighbour peaks, and the next grid begins at once.
// Throughput is one cell per clock unless the compare stage stalls. m_tvalid rises
// after the last cell is accepted: the accepting edge loads the cell register and
// issues the line buffer read, and the result register is then loaded from the
// compare and count logic. The line buffer holds the two previous rows.
// Reset sets the grid to one by one and clears the counters; the line buffer
// is not cleared, since entries are always written before use.
// If the receiver stalls, the result register holds its value. Cells of the
// next grid keep flowing until that grid's last cell, which waits in the
// compare stage and drops s_tready until the result register is free.
module grid_local_peak_counter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [glpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Cell input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [glpc_pkg::S_TDATA_W-1:0]    s_tdata,  // [31:0] cell_value
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [glpc_pkg::M_TDATA_W-1:0]    m_tdata   // [25:0] peak_total, zero above
);

    logic                              s1_valid;
    glpc_pkg::glpc_pos_t               s1_pos;
    glpc_pkg::glpc_value_t             s1_value;
    logic                              s1_fire;
    logic                              rd_en;
    logic [glpc_pkg::COL_W-1:0]        rd_addr;
    logic [glpc_pkg::RAM_W-1:0]        rd_data;
    logic                              wr_en;
    logic [glpc_pkg::COL_W-1:0]        wr_addr;
    logic [glpc_pkg::RAM_W-1:0]        wr_data;
    logic                              cfg_restart;
    logic [glpc_pkg::PEAK_W-1:0]       peak_total;

    // Configuration is always taken in the cycle it is offered.
    assign cfg_ready = 1'b1;

    glpc_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s1_valid    (s1_valid),
        .s1_pos      (s1_pos),
        .s1_value    (s1_value),
        .s1_fire     (s1_fire),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .cfg_restart (cfg_restart)
    );

    // Each entry holds the two rows above one column: the upper row in the
    // high half and the row just above in the low half.
    glpc_ram #(
        .WIDTH (glpc_pkg::RAM_W),
        .DEPTH (glpc_pkg::MAX_COLUMNS)
    ) u_line_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    glpc_peak u_peak (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s1_valid     (s1_valid),
        .s1_pos       (s1_pos),
        .s1_value     (s1_value),
        .s1_fire      (s1_fire),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cfg_restart  (cfg_restart),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_peak_total (peak_total)
    );

    assign m_tdata = {{(glpc_pkg::M_TDATA_W - glpc_pkg::PEAK_W){1'b0}}, peak_total};

endmodule

// ----- rtl/core/glpc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. A read colliding with a write returns the old data.
module glpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/glpc_scan.sv -----
// Input stage: configuration registers, raster position counters and the
// cell register that feeds the compare stage. Depends on glpc_pkg.
module glpc_scan (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [glpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [glpc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [glpc_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               s1_valid,
    output glpc_pkg::glpc_pos_t                s1_pos,
    output glpc_pkg::glpc_value_t              s1_value,
    input  logic                               s1_fire,
    output logic                               rd_en,
    output logic [glpc_pkg::COL_W-1:0]         rd_addr,
    output logic                               cfg_restart
);

    `include "grid_local_peak_counter_assert.svh"

    logic [glpc_pkg::ROW_W-1:0] rows_last_reg, rows_last_next;
    logic [glpc_pkg::COL_W-1:0] cols_last_reg, cols_last_next;
    logic [glpc_pkg::ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [glpc_pkg::COL_W-1:0] col_pos_reg, col_pos_next;
    logic                       s1_valid_reg, s1_valid_next;
    glpc_pkg::glpc_pos_t        s1_pos_reg;
    glpc_pkg::glpc_value_t      s1_value_reg;

    logic                                accept;
    logic                                last_col;
    logic                                last_row;
    logic [glpc_pkg::CFG_COLS_W-1:0]     raw_cols;
    glpc_pkg::glpc_pos_t                 pos_now;

    assign s_tready = !s1_valid_reg || s1_fire;
    assign accept   = s_tvalid && s_tready;
    assign last_col = (col_pos_reg == cols_last_reg);
    assign last_row = (row_pos_reg == rows_last_reg);
    assign raw_cols = cfg_data[glpc_pkg::CFG_COLS_W-1:0];

    assign cfg_restart = cfg_valid &&
                         (cfg_index == glpc_pkg::REG_ROW_COUNT ||
                          cfg_index == glpc_pkg::REG_COLUMN_COUNT);

    always_comb begin
        pos_now.col      = col_pos_reg;
        pos_now.c_ge1    = (col_pos_reg != '0);
        pos_now.c_ge2    = (col_pos_reg > glpc_pkg::COL_W'(1));
        pos_now.r_ge1    = (row_pos_reg != '0);
        pos_now.r_ge2    = (row_pos_reg > glpc_pkg::ROW_W'(1));
        pos_now.last_row = last_row;
        pos_now.last_col = last_col;
    end

    always_comb begin
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        s1_valid_next  = s1_valid_reg;

        if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
        if (accept) begin
            s1_valid_next = 1'b1;
            if (!last_col) begin
                col_pos_next = col_pos_reg + glpc_pkg::COL_W'(1);
            end else begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + glpc_pkg::ROW_W'(1);
            end
        end

        // The user must send configuration only while the block is idle; the block does not enforce it.
        if (cfg_valid) begin
            case (cfg_index)
                glpc_pkg::REG_ROW_COUNT: begin
                    // A count of zero behaves as one row.
                    rows_last_next = (cfg_data == '0) ? '0
                                   : cfg_data - glpc_pkg::ROW_W'(1);
                end
                glpc_pkg::REG_COLUMN_COUNT: begin
                    if (raw_cols == '0) begin
                        cols_last_next = '0;
                    end else if (32'(raw_cols) > 32'(glpc_pkg::MAX_COLUMNS)) begin
                        cols_last_next = glpc_pkg::COL_W'(glpc_pkg::MAX_COLUMNS - 1);
                    end else begin
                        cols_last_next = glpc_pkg::COL_W'(32'(raw_cols) - 32'd1);
                    end
                end
                default: begin
                end
            endcase
        end
        if (cfg_restart) begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_last_reg <= '0;
            cols_last_reg <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            rows_last_reg <= rows_last_next;
            cols_last_reg <= cols_last_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pos_reg   <= pos_now;
            s1_value_reg <= $signed(s_tdata[glpc_pkg::VALUE_WIDTH-1:0]);
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_pos   = s1_pos_reg;
    assign s1_value = s1_value_reg;
    assign rd_en    = accept;
    assign rd_addr  = col_pos_reg;

    `GLPC_ASSERT_NEXT(a_cfg_restarts_grid, cfg_restart,
        (row_pos_reg == '0) && (col_pos_reg == '0), "grid not restarted by config write")
    `GLPC_ASSERT_NEXT(a_row_wrap, accept && !cfg_valid && last_col && !last_row,
        (col_pos_reg == '0) && (row_pos_reg == $past(row_pos_reg) + 16'd1),
        "row did not advance at end of line")

endmodule

// ----- rtl/core/glpc_peak.sv -----
// Compare stage: neighbour window, peak decisions, running count and the
// result register. Depends on glpc_pkg and the line buffer RAM read data.
module glpc_peak (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s1_valid,
    input  glpc_pkg::glpc_pos_t            s1_pos,
    input  glpc_pkg::glpc_value_t          s1_value,
    output logic                           s1_fire,
    input  logic                           rd_en,
    input  logic [glpc_pkg::COL_W-1:0]     rd_addr,
    input  logic [glpc_pkg::RAM_W-1:0]     rd_data,
    output logic                           wr_en,
    output logic [glpc_pkg::COL_W-1:0]     wr_addr,
    output logic [glpc_pkg::RAM_W-1:0]     wr_data,
    input  logic                           cfg_restart,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [glpc_pkg::PEAK_W-1:0]    m_peak_total
);

    `include "grid_local_peak_counter_assert.svh"

    localparam int VW = glpc_pkg::VALUE_WIDTH;

    logic                           bypass_reg, bypass_next;
    logic [glpc_pkg::RAM_W-1:0]     bypass_word_reg;
    logic [glpc_pkg::PEAK_W-1:0]    running_reg, running_next;
    logic                           m_valid_reg, m_valid_next;
    logic [glpc_pkg::PEAK_W-1:0]    m_data_reg;

    // Window: previous-row values one and two columns back, the row above
    // that one column back, and current-row values one and two columns back.
    glpc_pkg::glpc_value_t prev_a_reg;
    glpc_pkg::glpc_value_t prev2_a_reg;
    glpc_pkg::glpc_value_t prev_u_reg;
    glpc_pkg::glpc_value_t win1_reg;
    glpc_pkg::glpc_value_t win2_reg;

    logic [glpc_pkg::RAM_W-1:0]  word;
    glpc_pkg::glpc_value_t       cur_a;
    glpc_pkg::glpc_value_t       cur_u;
    glpc_pkg::glpc_value_t       v;
    logic                        grid_end;
    logic                        d_left_above;
    logic                        d_above;
    logic                        d_left;
    logic                        d_self;
    logic [2:0]                  found;
    logic [glpc_pkg::PEAK_W-1:0] total;

    // A read issued while the same line entry was being written sees the
    // new word through the bypass; this only occurs with a single column.
    assign word  = bypass_reg ? bypass_word_reg : rd_data;
    assign cur_a = $signed(word[VW-1:0]);
    assign cur_u = $signed(word[2*VW-1:VW]);
    assign v     = s1_value;

    assign grid_end = s1_pos.last_row && s1_pos.last_col;
    assign s1_fire  = s1_valid && (!grid_end || !m_valid_reg || m_tready);

    // Cell one row up and one column left: all four sides are now known.
    assign d_left_above = s1_pos.r_ge1 && s1_pos.c_ge1 &&
                          (cur_a < prev_a_reg) && (win1_reg < prev_a_reg) &&
                          (!s1_pos.r_ge2 || (prev_u_reg < prev_a_reg)) &&
                          (!s1_pos.c_ge2 || (prev2_a_reg < prev_a_reg));

    // Cell directly above, in the last column: it has no right neighbour.
    assign d_above = s1_pos.r_ge1 && s1_pos.last_col && (v < cur_a) &&
                     (!s1_pos.r_ge2 || (cur_u < cur_a)) &&
                     (!s1_pos.c_ge1 || (prev_a_reg < cur_a));

    // Bottom row: the cell to the left has no lower neighbour.
    assign d_left = s1_pos.last_row && s1_pos.c_ge1 && (v < win1_reg) &&
                    (!s1_pos.c_ge2 || (win2_reg < win1_reg)) &&
                    (!s1_pos.r_ge1 || (prev_a_reg < win1_reg));

    // Final cell of the grid; a lone cell is never counted.
    assign d_self = grid_end && (s1_pos.r_ge1 || s1_pos.c_ge1) &&
                    (!s1_pos.c_ge1 || (win1_reg < v)) &&
                    (!s1_pos.r_ge1 || (cur_a < v));

    assign found = {2'b00, d_left_above} + {2'b00, d_above} +
                   {2'b00, d_left} + {2'b00, d_self};
    assign total = running_reg + glpc_pkg::PEAK_W'(found);

    assign wr_en   = s1_fire;
    assign wr_addr = s1_pos.col;
    assign wr_data = {cur_a, v};

    always_comb begin
        bypass_next  = bypass_reg;
        running_next = running_reg;
        m_valid_next = m_valid_reg;

        if (rd_en) begin
            bypass_next = s1_fire && (rd_addr == s1_pos.col);
        end
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s1_fire) begin
            running_next = grid_end ? '0 : total;
            if (grid_end) begin
                m_valid_next = 1'b1;
            end
        end
        if (cfg_restart) begin
            running_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bypass_reg  <= 1'b0;
            running_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            bypass_reg  <= bypass_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            bypass_word_reg <= wr_data;
        end
        if (s1_fire) begin
            prev2_a_reg <= prev_a_reg;
            prev_a_reg  <= cur_a;
            prev_u_reg  <= cur_u;
            win2_reg    <= win1_reg;
            win1_reg    <= v;
            if (grid_end) begin
                m_data_reg <= total;
            end
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_peak_total = m_data_reg;

    `GLPC_ASSERT_NEXT(a_end_gives_result, s1_fire && grid_end, m_valid_reg,
        "grid end did not produce a result")
    `GLPC_ASSERT_NEXT(a_end_clears_count, s1_fire && grid_end, running_reg == '0,
        "running count not cleared after grid end")
    `GLPC_ASSERT_NEXT(a_bypass_needs_write, rd_en && !s1_fire, !bypass_reg,
        "bypass taken without a concurrent line write")
    `GLPC_ASSERT_SAME(a_stall_only_when_full, s1_valid && !s1_fire,
        grid_end && m_valid_reg && !m_tready, "compare stage stalled without cause")

endmodule

// ----- test/grid_local_peak_counter_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the grid peak counter: watches the cfg, s_ and m_ channels,
// keeps its own model of the grid scan and checks every peak total.
// Depends on glpc_pkg only.
module grid_local_peak_counter_checker
    import glpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int                     mismatches,
    output int                     results_pending
);

    glpc_value_t       upper_row [MAX_COLUMNS];
    glpc_value_t       middle_row [MAX_COLUMNS];
    glpc_value_t       left_above;
    glpc_value_t       back_one;
    glpc_value_t       back_two;
    int unsigned       row_at;
    int unsigned       col_at;
    logic [PEAK_W-1:0] peak_sum;
    logic [ROW_W-1:0]  rows_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    logic [PEAK_W-1:0] expected_totals [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic restart_grid();
        row_at   = 0;
        col_at   = 0;
        peak_sum = '0;
    endtask

    task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_ROW_COUNT) begin
            rows_reg = data[ROW_W-1:0];
            restart_grid();
        end else if (idx == REG_COLUMN_COUNT) begin
            cols_reg = data[CFG_COLS_W-1:0];
            restart_grid();
        end
    endtask

    // Each cell settles the cell above it, and on the last row also the cell
    // to its left; the very last cell of the grid settles itself.
    task automatic take_cell(input glpc_value_t v);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned found;
        glpc_value_t above;
        glpc_value_t centre;
        bit          last_row;
        bit          last_col;
        bit          ok;
        rows = (rows_reg == '0) ? 1 : rows_reg;
        cols = (cols_reg == '0) ? 1 : cols_reg;
        if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
        r = (row_at >= rows) ? rows - 1 : row_at;
        c = (col_at >= cols) ? cols - 1 : col_at;
        last_row = (r + 1 == rows);
        last_col = (c + 1 == cols);
        above = middle_row[c];
        found = 0;
        if (r >= 1) begin
            ok = (v < above);
            if (r >= 2 && !(upper_row[c] < above)) ok = 1'b0;
            if (c >= 1 && !(left_above < above)) ok = 1'b0;
            if (c + 1 < cols && !(middle_row[c + 1] < above)) ok = 1'b0;
            found += ok;
        end
        if (last_row) begin
            if (c >= 1) begin
                centre = back_one;
                ok = (v < centre);
                if (c >= 2 && !(back_two < centre)) ok = 1'b0;
                if (r >= 1 && !(left_above < centre)) ok = 1'b0;
                found += ok;
            end
            if (last_col && (r >= 1 || c >= 1)) begin
                ok = 1'b1;
                if (c >= 1 && !(back_one < v)) ok = 1'b0;
                if (r >= 1 && !(above < v)) ok = 1'b0;
                found += ok;
            end
        end
        upper_row[c]  = above;
        left_above    = above;
        middle_row[c] = v;
        back_two      = back_one;
        back_one      = v;
        peak_sum      = peak_sum + PEAK_W'(found);
        if (!last_col) begin
            col_at = c + 1;
            row_at = r;
        end else begin
            col_at = 0;
            if (!last_row) begin
                row_at = r + 1;
            end else begin
                expected_totals = {expected_totals, peak_sum};
                restart_grid();
            end
        end
    endtask

    always @(posedge aclk) begin
        logic [PEAK_W-1:0] want;
        if (!aresetn) begin
            expected_totals.delete();
            restart_grid();
            left_above = '0;
            back_one   = '0;
            back_two   = '0;
            rows_reg   = ROW_W'(1);
            cols_reg   = CFG_COLS_W'(1);
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_totals.size() == 0) begin
                    report_mismatch($sformatf("result 0x%0h with no grid finished", m_tdata));
                end else begin
                    want = expected_totals.pop_front();
                    if (m_tdata !== M_TDATA_W'(want))
                        report_mismatch($sformatf("peak total 0x%0h, want 0x%0h",
                                                  m_tdata, want));
                end
            end
            if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) take_cell(glpc_value_t'(s_tdata));
        end
        results_pending = expected_totals.size();
    end

endmodule

// ----- test/grid_local_peak_counter_test.sv -----
`timescale 1ns / 100ps
// Top of the grid peak counter testbench: clock, reset, stimulus and verdict.
// Depends on glpc_pkg, grid_local_peak_counter and grid_local_peak_counter_checker.
module grid_local_peak_counter_test;
    import glpc_pkg::*;

    // Cycles allowed after the last result before the block counts as idle.
    // The result is registered right behind the cell register, so this is ample.
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // Least number of cells sent by the random part; the directed part adds about 25 more.
    localparam int RANDOM_CELLS = 1325;
    localparam int IDLE_PERCENT = 7;

    // Value patterns used to fill a grid. Narrow and binary values give many
    // ties, which is where strict comparison matters most.
    typedef enum int {
        PATTERN_NARROW,
        PATTERN_WIDE,
        PATTERN_EXTREME,
        PATTERN_BINARY
    } pattern_e;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;  // [31:0] cell_value
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;         // [25:0] peak_total, zero above

    int          mismatches;
    int          results_pending;
    int unsigned cycle_count = 0;
    logic        no_idling   = 1'b0;

    // Stimulus bookkeeping: the register words last written and the number
    // of cells that one grid of that size takes.
    logic [CFG_DATA_W-1:0] row_word      = CFG_DATA_W'(1);
    logic [CFG_DATA_W-1:0] col_word      = CFG_DATA_W'(1);
    int                    cells_per_grid = 1;

    grid_local_peak_counter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    grid_local_peak_counter_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver stalls now and then, except during the steady stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idling || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Cells in the grid as the block sees it: a zero size acts as one, and
    // the column count is cut to eleven bits and then to the buffer depth.
    function automatic int grid_cells(input logic [CFG_DATA_W-1:0] rows,
                                      input logic [CFG_DATA_W-1:0] cols);
        int r;
        int c;
        r = (rows[ROW_W-1:0] == '0) ? 1 : rows[ROW_W-1:0];
        c = (cols[CFG_COLS_W-1:0] == '0) ? 1 : cols[CFG_COLS_W-1:0];
        if (c > MAX_COLUMNS) c = MAX_COLUMNS;
        return r * c;
    endfunction

    function automatic glpc_value_t make_value(input pattern_e pattern);
        case (pattern)
            PATTERN_NARROW:  return glpc_value_t'(int'($urandom_range(6)) - 3);
            PATTERN_WIDE:    return glpc_value_t'($urandom);
            PATTERN_EXTREME: begin
                case ($urandom_range(6))
                    0:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1:       return {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
                    2:       return '1;
                    3:       return '0;
                    4:       return glpc_value_t'(1);
                    5:       return {1'b0, {(VALUE_WIDTH-2){1'b1}}, 1'b0};
                    default: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                endcase
            end
            default:         return glpc_value_t'($urandom_range(1));
        endcase
    endfunction

    // Lowers s_tvalid, waits until every finished grid has produced its
    // result, then lets the pipeline drain so that a register write lands on
    // an idle block. The first edge makes sure the checker has seen the last
    // cell before the pending count is trusted.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One cfg transaction. The valid is dropped and an edge is awaited afterwards,
    // so a following write never lowers and raises it in the same step.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_ROW_COUNT) row_word = data;
        else if (idx == REG_COLUMN_COUNT) col_word = data;
        cells_per_grid = grid_cells(row_word, col_word);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] rows,
                            input logic [CFG_DATA_W-1:0] cols);
        drain_results();
        write_register(REG_ROW_COUNT, rows);
        write_register(REG_COLUMN_COUNT, cols);
    endtask

    // One s_ transaction, preceded by random idle cycles. When no gap is
    // taken, s_tvalid simply stays high into the next transaction.
    task automatic send_cell(input glpc_value_t v);
        while (!no_idling && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_grid(input pattern_e pattern);
        repeat (cells_per_grid) send_cell(make_value(pattern));
    endtask

    initial begin
        int       round;
        int       cells_sent;
        int       partial;
        int       pick;
        logic [CFG_DATA_W-1:0] rows;
        logic [CFG_DATA_W-1:0] cols;
        pattern_e pattern;

        cells_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // Lone cell at the reset size of one by one: never counted.
        send_cell({1'b0, {(VALUE_WIDTH-1){1'b1}}});

        // Three by three with the largest value in the middle and the most
        // negative value all around.
        set_size(CFG_DATA_W'(3), CFG_DATA_W'(3));
        for (int i = 0; i < 9; i++)
            send_cell((i == 4) ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                               : {1'b1, {(VALUE_WIDTH-1){1'b0}}});

        // Single row: both ends are peaks against one neighbour each.
        set_size(CFG_DATA_W'(1), CFG_DATA_W'(4));
        send_cell(glpc_value_t'(5));
        send_cell(glpc_value_t'(1));
        send_cell(glpc_value_t'(1));
        send_cell(glpc_value_t'(7));

        // Single column with negative values between the peaks.
        set_size(CFG_DATA_W'(4), CFG_DATA_W'(1));
        send_cell(glpc_value_t'(3));
        send_cell(glpc_value_t'(-5));
        send_cell(glpc_value_t'(2));
        send_cell(glpc_value_t'(-8));

        // Zero sizes act as one by one; a write to an unknown index is
        // ignored and must not disturb the grid.
        set_size('0, '0);
        write_register(CFG_INDEX_W'(REG_COLUMN_COUNT + 1), CFG_DATA_W'(5));
        send_cell(glpc_value_t'(-1));

        // A register write in the middle of a grid restarts it.
        set_size(CFG_DATA_W'(2), CFG_DATA_W'(2));
        send_cell(glpc_value_t'(9));
        send_cell(glpc_value_t'(9));
        drain_results();
        write_register(REG_ROW_COUNT, CFG_DATA_W'(2));
        send_cell(glpc_value_t'(4));
        send_cell(glpc_value_t'(-4));
        send_cell(glpc_value_t'(0));
        send_cell(glpc_value_t'(6));

        // Random part: mostly small grids sent back to back with random
        // content, a tall grid, a wide two-row grid, one row at the full buffer
        // depth, some aborted grids and some writes to unknown indexes.
        for (round = 0; round < 7 || cells_sent < RANDOM_CELLS; round++) begin
            no_idling <= (round == 5);
            case (round)
                1: begin
                    set_size(CFG_DATA_W'(30), CFG_DATA_W'(1));
                    send_grid(PATTERN_NARROW);
                    cells_sent += cells_per_grid;
                end
                3: begin
                    set_size(CFG_DATA_W'(2), CFG_DATA_W'(20));
                    send_grid(PATTERN_BINARY);
                    cells_sent += cells_per_grid;
                end
                5: begin
                    // All eleven column bits set: cut to the buffer depth.
                    set_size(CFG_DATA_W'(1), CFG_DATA_W'(16'h07FF));
                    send_grid(PATTERN_EXTREME);
                    cells_sent += cells_per_grid;
                end
                default: ;
            endcase

            pick = $urandom_range(99);
            if (pick < 70) begin
                rows = CFG_DATA_W'($urandom_range(4, 1));
                cols = CFG_DATA_W'($urandom_range(5, 1));
            end else if (pick < 95) begin
                rows = CFG_DATA_W'($urandom_range(10, 1));
                cols = CFG_DATA_W'($urandom_range(12, 1));
            end else begin
                rows = CFG_DATA_W'($urandom_range(2, 1));
                cols = CFG_DATA_W'($urandom_range(40, 1));
            end
            if ($urandom_range(99) < 5) rows = '0;
            if ($urandom_range(99) < 5) cols = '0;
            // Bits above the column field are ignored by the block.
            cols[CFG_DATA_W-1:CFG_COLS_W] = (CFG_DATA_W - CFG_COLS_W)'($urandom);

            drain_results();
            if ($urandom_range(99) < 8)
                write_register(CFG_INDEX_W'($urandom_range(255, REG_COLUMN_COUNT + 1)),
                               CFG_DATA_W'($urandom));
            // Every round writes at least one register, which also restarts
            // any grid that the previous round left unfinished.
            case ($urandom_range(2))
                0: begin
                    write_register(REG_ROW_COUNT, rows);
                    write_register(REG_COLUMN_COUNT, cols);
                end
                1:       write_register(REG_ROW_COUNT, rows);
                default: write_register(REG_COLUMN_COUNT, cols);
            endcase

            repeat ($urandom_range(3, 1)) begin
                pattern = pattern_e'($urandom_range(3));
                send_grid(pattern);
                cells_sent += cells_per_grid;
                if ($urandom_range(99) < 10) drain_results();
            end

            if (cells_per_grid > 1 && $urandom_range(99) < 12) begin
                partial = $urandom_range(cells_per_grid - 1, 1);
                repeat (partial) send_cell(make_value(PATTERN_WIDE));
                cells_sent += partial;
            end
        end

        drain_results();
        if (mismatches == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
